@@ src/lcb_pkg.sv @@
// lcb_pkg: shared types, codes and constants for the latency circuit breaker
// no dependencies; imported by lcb_div, lcb_ewma and latency_circuit_breaker
`timescale 1ns / 1ps

package lcb_pkg;

   localparam int LATENCY_BITS_DEF = 20;
   localparam int FRAC_BITS        = 8;
   localparam int RESP_W           = 20;
   localparam int LOAD_W           = 16;
   localparam int CLOCK_W          = 32;
   localparam int COUNT_W          = 32;
   localparam int OUT_Q8_W         = 28;
   localparam int CONSEC_W         = 8;
   localparam int INTERVAL_W       = 16;
   localparam int FALLBACK_W       = 20;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 20;

   localparam logic [FRAC_BITS-1:0]  WEIGHT_RST   = 8'd26;
   localparam logic [CONSEC_W-1:0]   TLIMIT_RST   = 8'd3;
   localparam logic [LOAD_W-1:0]     LLIMIT_RST   = 16'd1000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd1000;
   localparam logic [FALLBACK_W-1:0] FALLBACK_RST = 20'd1000;

   typedef enum logic [1:0] {
      ACT_COMPLETE = 2'd0,
      ACT_TICK     = 2'd1,
      ACT_PROBE    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MODE_UP   = 2'd0,
      MODE_DOWN = 2'd1,
      MODE_HALF = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EWMA_WEIGHT    = 3'd0,
      CSR_TIMEOUT_LIMIT  = 3'd1,
      CSR_LOAD_LIMIT     = 3'd2,
      CSR_PROBE_INTERVAL = 3'd3,
      CSR_PROBE_FALLBACK = 3'd4
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EWMA,
      ST_DIV,
      ST_TRIP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic exec;
      logic ewma_load;
      logic mean_load;
      logic trip_check;
      logic rsp_load;
   } ctrl_type;

endpackage

@@ src/latency_circuit_breaker.sv @@
// latency_circuit_breaker: endpoint health tracker, top level with sequencer
// depends on lcb_pkg, lcb_ewma and lcb_div
`timescale 1ns / 1ps

// One word in gives one word out. Tick, probe-response and unknown words pass
// through EXEC and DONE to the result register; a completion word passes
// through EXEC, EWMA, DIV, TRIP and DONE: the cumulative mean goes through a
// bit-serial divider of DIV_W = max(LATENCY_BITS + 8, 32) + 1 quotient bits
// that retires one quotient bit per cycle, while the EWMA products run
// alongside it. The block takes one word at a time; req_stall is high from
// the cycle after acceptance until the result has been loaded into the output
// register, and a new word may be taken while that result still waits. Latency
// values are unsigned Q.8 milliseconds; the total timeout count saturates.
module latency_circuit_breaker import lcb_pkg::*; #(
   parameter int LATENCY_BITS = LATENCY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [RESP_W-1:0]     req_response_ms,
   input  logic                  req_timed_out,
   input  logic [LOAD_W-1:0]     req_active_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_link_state,
   output logic                  rsp_probe_sent,
   output logic [OUT_Q8_W-1:0]   rsp_ewma_latency_q8,
   output logic [OUT_Q8_W-1:0]   rsp_mean_latency_q8,
   output logic [COUNT_W-1:0]    rsp_total_timeouts,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int Q8_W     = LATENCY_BITS + FRAC_BITS;
   localparam int LAT_Q8_W = CLOCK_W + FRAC_BITS;
   localparam int CMP_W    = LAT_Q8_W + 1;
   localparam int DIV_W    = ((Q8_W > COUNT_W) ? Q8_W : COUNT_W) + 1;

   state_type state_ff, state_in;
   ctrl_type  ctrl;
   logic      slot_free;

   // configuration
   logic [FRAC_BITS-1:0]  weight_ff, weight_in;
   logic [CONSEC_W-1:0]   tlimit_ff, tlimit_in;
   logic [LOAD_W-1:0]     llimit_ff, llimit_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [FALLBACK_W-1:0] fallback_ff, fallback_in;

   // breaker state
   mode_type              mode_ff, mode_in;
   logic [CONSEC_W-1:0]   consec_ff, consec_in;
   logic [COUNT_W-1:0]    tout_total_ff, tout_total_in;
   logic [COUNT_W-1:0]    completions_ff, completions_in;
   logic [Q8_W-1:0]       ewma_ff, ewma_in;
   logic [Q8_W-1:0]       mean_ff, mean_in;
   logic [LOAD_W-1:0]     load_ff, load_in;
   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [CLOCK_W-1:0]    clock_ms_ff, clock_ms_in;
   logic [CLOCK_W-1:0]    probe_start_ff, probe_start_in;

   // captured word and per-word scratch
   logic [1:0]            action_ff, action_in;
   logic [RESP_W-1:0]     rt_ff, rt_in;
   logic                  late_ff, late_in;
   logic [LOAD_W-1:0]     active_ff, active_in;
   logic                  sent_ff, sent_in;
   logic                  seed_ff, seed_in;
   logic                  pos_ff, pos_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_link_ff;
   logic                  rsp_probe_ff;
   logic [OUT_Q8_W-1:0]   rsp_ewma_ff;
   logic [OUT_Q8_W-1:0]   rsp_mean_ff;
   logic [COUNT_W-1:0]    rsp_total_ff;

   // datapath helpers
   logic [Q8_W-1:0]       sample;
   logic [Q8_W-1:0]       ewma_next;
   logic [COUNT_W-1:0]    comp_next;
   logic [DIV_W-1:0]      xh;
   logic [DIV_W-1:0]      mean_w;
   logic [DIV_W-1:0]      div_dividend;
   logic [DIV_W-1:0]      div_q;
   logic [COUNT_W-1:0]    div_r;
   logic                  div_start;
   logic                  div_busy;
   logic [CLOCK_W-1:0]    lat;
   logic [LAT_Q8_W-1:0]   lat_q8;
   logic [CMP_W-1:0]      mean2_wide;
   logic                  lat_sat;
   logic                  probe_ok;
   logic                  go_down_req;

   assign sample = Q8_W'({rt_ff, {FRAC_BITS{1'b0}}});

   lcb_ewma #(
      .Q8_W (Q8_W)
   ) u_ewma (
      .clock  (clock),
      .load   (ctrl.exec),
      .sample (sample),
      .prev   (ewma_ff),
      .weight (weight_ff),
      .result (ewma_next)
   );

   lcb_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (COUNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (comp_next),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (action_ff == ACT_COMPLETE) ? ST_EWMA : ST_DONE;
         end
         ST_EWMA: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) state_in = ST_TRIP;
         end
         ST_TRIP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer: outputs
   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
         end
         ST_EWMA: begin
            ctrl.ewma_load = 1'b1;
         end
         ST_DIV: begin
            ctrl.mean_load = !div_busy;
         end
         ST_TRIP: begin
            ctrl.trip_check = 1'b1;
         end
         ST_DONE: begin
            ctrl.rsp_load = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath
   always_comb begin
      weight_in      = weight_ff;
      tlimit_in      = tlimit_ff;
      llimit_in      = llimit_ff;
      interval_in    = interval_ff;
      fallback_in    = fallback_ff;
      mode_in        = mode_ff;
      consec_in      = consec_ff;
      tout_total_in  = tout_total_ff;
      completions_in = completions_ff;
      ewma_in        = ewma_ff;
      mean_in        = mean_ff;
      load_in        = load_ff;
      countdown_in   = countdown_ff;
      clock_ms_in    = clock_ms_ff;
      probe_start_in = probe_start_ff;
      action_in      = action_ff;
      rt_in          = rt_ff;
      late_in        = late_ff;
      active_in      = active_ff;
      sent_in        = sent_ff;
      seed_in        = seed_ff;
      pos_in         = pos_ff;
      go_down_req    = 1'b0;

      comp_next    = (completions_ff == '1) ? completions_ff : completions_ff + 1'b1;
      xh           = DIV_W'(sample) + DIV_W'(comp_next >> 1);
      mean_w       = DIV_W'(mean_ff);
      div_dividend = (xh >= mean_w) ? xh - mean_w : mean_w - xh;
      div_start    = 1'b0;

      lat        = clock_ms_ff - probe_start_ff;
      lat_q8     = {lat, {FRAC_BITS{1'b0}}};
      mean2_wide = CMP_W'(mean_ff) << 1;
      lat_sat    = (lat_q8 >> Q8_W) != '0;
      probe_ok   = (completions_ff != '0) ? (CMP_W'(lat_q8) < mean2_wide)
                                          : (lat < CLOCK_W'(fallback_ff));

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EWMA_WEIGHT:    weight_in   = csr_wdata[FRAC_BITS-1:0];
            CSR_TIMEOUT_LIMIT:  tlimit_in   = csr_wdata[CONSEC_W-1:0];
            CSR_LOAD_LIMIT:     llimit_in   = csr_wdata[LOAD_W-1:0];
            CSR_PROBE_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_PROBE_FALLBACK: fallback_in = csr_wdata[FALLBACK_W-1:0];
            default: begin
            end
         endcase
      end

      if (!req_stall && req_valid) begin
         action_in = req_action;
         rt_in     = req_response_ms;
         late_in   = req_timed_out;
         active_in = req_active_count;
      end

      if (ctrl.exec) begin
         sent_in = 1'b0;
         case (action_ff)
            ACT_COMPLETE: begin
               div_start      = 1'b1;
               seed_in        = (ewma_ff == '0);
               pos_in         = (xh >= mean_w);
               completions_in = comp_next;
               if (late_ff) begin
                  if (consec_ff != '1) consec_in = consec_ff + 1'b1;
                  if (tout_total_ff != '1) tout_total_in = tout_total_ff + 1'b1;
               end else begin
                  consec_in = '0;
               end
            end
            ACT_TICK: begin
               clock_ms_in = clock_ms_ff + 1'b1;
               if (countdown_ff != '0) begin
                  countdown_in = countdown_ff - 1'b1;
                  // countdown expiry while down launches the probe
                  if (countdown_ff == INTERVAL_W'(1) && mode_ff == MODE_DOWN) begin
                     probe_start_in = clock_ms_ff + 1'b1;
                     mode_in        = MODE_HALF;
                     sent_in        = 1'b1;
                  end
               end
            end
            ACT_PROBE: begin
               if (mode_ff == MODE_HALF) begin
                  if (probe_ok) begin
                     load_in      = active_ff;
                     ewma_in      = lat_sat ? '1 : Q8_W'(lat_q8);
                     mode_in      = MODE_UP;
                     consec_in    = '0;
                     countdown_in = '0;
                  end else begin
                     go_down_req = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (ctrl.ewma_load) begin
         ewma_in = seed_ff ? sample : ewma_next;
      end

      if (ctrl.mean_load) begin
         // rounding toward +inf on the way down keeps the mean rounded half up
         mean_in = pos_ff ? Q8_W'(mean_w + div_q)
                          : Q8_W'(mean_w - div_q - DIV_W'(div_r != '0));
      end

      if (ctrl.trip_check && mode_ff == MODE_UP) begin
         go_down_req = (consec_ff >= tlimit_ff) || (load_ff >= llimit_ff)
                    || ((completions_ff != '0) && ({1'b0, ewma_ff} >= {mean_ff, 1'b0}));
      end

      if (go_down_req && mode_ff != MODE_DOWN) begin
         mode_in      = MODE_DOWN;
         consec_in    = '0;
         countdown_in = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
      end

      rsp_valid_in = ctrl.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         weight_ff      <= WEIGHT_RST;
         tlimit_ff      <= TLIMIT_RST;
         llimit_ff      <= LLIMIT_RST;
         interval_ff    <= INTERVAL_RST;
         fallback_ff    <= FALLBACK_RST;
         mode_ff        <= MODE_UP;
         consec_ff      <= '0;
         tout_total_ff  <= '0;
         completions_ff <= '0;
         ewma_ff        <= '0;
         mean_ff        <= '0;
         load_ff        <= '0;
         countdown_ff   <= '0;
         clock_ms_ff    <= '0;
         probe_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         weight_ff      <= weight_in;
         tlimit_ff      <= tlimit_in;
         llimit_ff      <= llimit_in;
         interval_ff    <= interval_in;
         fallback_ff    <= fallback_in;
         mode_ff        <= mode_in;
         consec_ff      <= consec_in;
         tout_total_ff  <= tout_total_in;
         completions_ff <= completions_in;
         ewma_ff        <= ewma_in;
         mean_ff        <= mean_in;
         load_ff        <= load_in;
         countdown_ff   <= countdown_in;
         clock_ms_ff    <= clock_ms_in;
         probe_start_ff <= probe_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      rt_ff     <= rt_in;
      late_ff   <= late_in;
      active_ff <= active_in;
      sent_ff   <= sent_in;
      seed_ff   <= seed_in;
      pos_ff    <= pos_in;
      if (ctrl.rsp_load) begin
         rsp_link_ff  <= mode_ff;
         rsp_probe_ff <= sent_ff;
         rsp_ewma_ff  <= OUT_Q8_W'(ewma_ff);
         rsp_mean_ff  <= OUT_Q8_W'(mean_ff);
         rsp_total_ff <= tout_total_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_state      = rsp_link_ff;
   assign rsp_probe_sent      = rsp_probe_ff;
   assign rsp_ewma_latency_q8 = rsp_ewma_ff;
   assign rsp_mean_latency_q8 = rsp_mean_ff;
   assign rsp_total_timeouts  = rsp_total_ff;

`ifndef SYNTHESIS
   // the probe countdown is armed exactly while the link is down
   a_countdown_armed: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DOWN) == (countdown_ff != '0))
      else $error("probe countdown out of step with link mode");

   // a word is taken only from idle and goes straight to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted word did not start execution");

   // the divider only runs while a completion is in flight
   a_div_window: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_EWMA || state_ff == ST_DIV))
      else $error("divider busy outside completion sequence");

   // a probe is only reported together with the half-open state
   a_probe_half: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_probe_sent) |-> (rsp_link_state == MODE_HALF))
      else $error("probe reported without half-open state");
`endif

endmodule

@@ src/lcb_div.sv @@
// lcb_div: bit-serial restoring divider, one quotient bit per cycle
// depends on lcb_pkg
`timescale 1ns / 1ps

module lcb_div import lcb_pkg::*; #(
   parameter int DIVIDEND_W = COUNT_W + 1,
   parameter int DIVISOR_W  = COUNT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/lcb_ewma.sv @@
// lcb_ewma: weighted average step, products registered then summed and rounded
// depends on lcb_pkg
`timescale 1ns / 1ps

module lcb_ewma import lcb_pkg::*; #(
   parameter int Q8_W = LATENCY_BITS_DEF + FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [Q8_W-1:0]      sample,
   input  logic [Q8_W-1:0]      prev,
   input  logic [FRAC_BITS-1:0] weight,
   output logic [Q8_W-1:0]      result
);

   localparam int PA_W  = Q8_W + FRAC_BITS;
   localparam int PB_W  = Q8_W + FRAC_BITS + 1;
   localparam int SUM_W = Q8_W + FRAC_BITS + 2;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   logic [PA_W-1:0]      prod_a_ff, prod_a_in;
   logic [PB_W-1:0]      prod_b_ff, prod_b_in;
   logic [FRAC_BITS:0]   keep;
   logic [SUM_W-1:0]     sum;

   always_comb begin
      // weight of the old value is one minus the sample weight
      keep      = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, weight};
      prod_a_in = PA_W'(sample) * PA_W'(weight);
      prod_b_in = PB_W'(prev) * PB_W'(keep);
      sum       = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + ROUND_HALF;
      result    = Q8_W'(sum >> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

endmodule
